// ===== rtl/core/dpls_pkg.sv =====
// Shared types, constants and tables for the depth-to-laser-scan block.
`timescale 1ns / 1ps
package dpls_pkg;

  localparam int BIN_COUNT_DEF = 512;
  localparam int ROW_LIMIT_DEF = 512;

  // CORDIC working widths: 16-bit inputs times 256 plus gain headroom
  localparam int CW  = 27;
  localparam int AGW = 17;
  localparam int DFW = 18;
  localparam int PRW = 35;
  localparam int CORDIC_STEPS = 14;
  localparam int SQRT_STEPS   = 16;
  localparam int BIN_SHIFT    = 19;

  localparam logic signed [AGW-1:0] HALF_PI = 17'sd12868;
  // a product at or below this truncates to a negative bin
  localparam logic signed [PRW-1:0] IDX_NEG_LIM = -(PRW'(2 ** BIN_SHIFT));

  typedef enum logic [2:0] {
    CFG_FRAME_SKIP,
    CFG_MIN_HEIGHT,
    CFG_MAX_HEIGHT,
    CFG_START_ANGLE,
    CFG_BIN_SCALE,
    CFG_FIRST_ROW,
    CFG_LAST_ROW
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORDIC,
    ST_BIN,
    ST_IDX,
    ST_UPD,
    ST_RD,
    ST_SQINIT,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic cordic_step;
    logic bin_mul;
    logic idx_calc;
    logic upd;
    logic rd_issue;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic keep_now;
    logic clr_now;
    logic keep_q;
    logic clr_done;
    logic cordic_done;
    logic idx_ok;
    logic sqrt_done;
    logic out_free;
  } sts_t;

  // atan(2^-i) in Q3.13
  function automatic logic [12:0] atan_lut(input logic [3:0] i);
    logic [12:0] v;
    case (i)
      4'd0:    v = 13'd6434;
      4'd1:    v = 13'd3798;
      4'd2:    v = 13'd2007;
      4'd3:    v = 13'd1019;
      4'd4:    v = 13'd511;
      4'd5:    v = 13'd256;
      4'd6:    v = 13'd128;
      4'd7:    v = 13'd64;
      4'd8:    v = 13'd32;
      4'd9:    v = 13'd16;
      4'd10:   v = 13'd8;
      4'd11:   v = 13'd4;
      4'd12:   v = 13'd2;
      4'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/dpls_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface dpls_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               frame_start;
  logic [8:0]         row;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               depth_ok;
  logic [8:0]         read_bin;

  modport source (output valid, req_type, frame_start, row, point_x, point_y, point_z,
                  depth_ok, read_bin, input ready);
  modport sink (input valid, req_type, frame_start, row, point_x, point_y, point_z,
                depth_ok, read_bin, output ready);
endinterface

interface dpls_res_if;
  logic        valid;
  logic        ready;
  logic [8:0]  bin_number;
  logic [15:0] range_mm;

  modport source (output valid, bin_number, range_mm, input ready);
  modport sink (input valid, bin_number, range_mm, output ready);
endinterface

// ===== rtl/core/depth_points_to_laser_scan.sv =====
// Top level of the depth point stream to virtual laser scan block.
//
// Usage: req_i carries point and read transactions (valid/ready). A point
// transaction with frame_start may start a used frame (one in frame_skip),
// which clears the bin store; kept points are binned by bearing and each bin
// keeps its largest x*x+z*z. A read transaction returns one result on res_o:
// the bin number and the floor square root of that bin.
// Sequence, one transaction at a time (ready is low until it is done):
//   dropped point: taken in the idle state and discarded; kept point: 14 CORDIC
//   iterations of the single shift-add unit, then scale multiply, bin
//   address, read-modify-write of the bin RAM.
//   used frame start: the bin store is first cleared, one RAM row a cycle.
//   read: RAM read, 16 isqrt steps (one result bit each), result register load.
// Reset: the bin store is swept to zero, one RAM row a cycle, with ready low;
// config writes are taken throughout. Config registers reset to defaults.
// Stall: a result waits in the output register; the next transaction is
// still taken, and a following read holds until that register frees.
`timescale 1ns / 1ps
module depth_points_to_laser_scan #(
  parameter int BIN_COUNT = dpls_pkg::BIN_COUNT_DEF,
  parameter int ROW_LIMIT = dpls_pkg::ROW_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpls_req_if.sink    req_i,
  dpls_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import dpls_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  dpls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpls_datapath #(
    .BIN_COUNT (BIN_COUNT),
    .ROW_LIMIT (ROW_LIMIT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_i.req_type),
    .frame_start_i (req_i.frame_start),
    .row_i         (req_i.row),
    .point_x_i     (req_i.point_x),
    .point_y_i     (req_i.point_y),
    .point_z_i     (req_i.point_z),
    .depth_ok_i    (req_i.depth_ok),
    .read_bin_i    (req_i.read_bin),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .bin_number_o  (res_o.bin_number),
    .range_mm_o    (res_o.range_mm)
  );

endmodule

// ===== rtl/core/dpls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dpls_datapath.sv =====
// Datapath: config registers, frame gating, CORDIC bearing, binning, bin store, isqrt.
`timescale 1ns / 1ps
module dpls_datapath #(
  parameter int BIN_COUNT = dpls_pkg::BIN_COUNT_DEF,
  parameter int ROW_LIMIT = dpls_pkg::ROW_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpls_pkg::cmd_t     cmd_i,
  output dpls_pkg::sts_t     sts_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               req_type_i,
  input  logic               frame_start_i,
  input  logic [8:0]         row_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic               depth_ok_i,
  input  logic [8:0]         read_bin_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [8:0]         bin_number_o,
  output logic [15:0]        range_mm_o
);
  import dpls_pkg::*;

  localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  // configuration
  logic [7:0]         frame_skip_q;
  logic signed [15:0] min_h_q, max_h_q, start_q;
  logic [15:0]        scale_q;
  logic [8:0]         first_row_q, last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_skip_q <= 8'd2;
      min_h_q      <= -16'sd32768;
      max_h_q      <= 16'sd32767;
      start_q      <= -16'sd8192;
      scale_q      <= 16'd7334;
      first_row_q  <= 9'd119;
      last_row_q   <= 9'd359;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_SKIP:  frame_skip_q <= cfg_data_i[7:0];
        CFG_MIN_HEIGHT:  min_h_q      <= signed'(cfg_data_i);
        CFG_MAX_HEIGHT:  max_h_q      <= signed'(cfg_data_i);
        CFG_START_ANGLE: start_q      <= signed'(cfg_data_i);
        CFG_BIN_SCALE:   scale_q      <= cfg_data_i;
        CFG_FIRST_ROW:   first_row_q  <= cfg_data_i[8:0];
        CFG_LAST_ROW:    last_row_q   <= cfg_data_i[8:0];
        default:         ;
      endcase
    end
  end

  // frame decimation and point filter, evaluated on the incoming transaction
  logic [7:0] skip_q, cnt1;
  logic       fiu_q, fs_now, use_now, fiu_next, row_ok, y_ok;

  always_comb begin
    cnt1     = skip_q + 8'd1;
    fs_now   = !req_type_i && frame_start_i;
    use_now  = cnt1 >= frame_skip_q;
    fiu_next = fs_now ? use_now : fiu_q;
    row_ok   = ({23'd0, row_i} < 32'(ROW_LIMIT)) && (row_i >= first_row_q)
               && (row_i <= last_row_q);
    y_ok     = (point_y_i >= min_h_q) && (point_y_i <= max_h_q);
  end

  assign sts_o.is_read  = req_type_i;
  assign sts_o.clr_now  = fs_now && use_now;
  assign sts_o.keep_now = !req_type_i && fiu_next && depth_ok_i && (point_z_i != 16'sd0)
                          && row_ok && y_ok;

  // CORDIC pre-rotation into the right half plane
  logic signed [AGW-1:0] yy, xx, x0, y0, a0;

  always_comb begin
    yy = -AGW'(point_x_i);
    xx = AGW'(point_z_i);
    if (xx < 0) begin
      if (yy >= 0) begin
        x0 = yy;
        y0 = -xx;
        a0 = HALF_PI;
      end else begin
        x0 = -yy;
        y0 = xx;
        a0 = -HALF_PI;
      end
    end else begin
      x0 = xx;
      y0 = yy;
      a0 = '0;
    end
  end

  logic signed [CW-1:0]  x_q, y_q, dx, dy;
  logic signed [AGW-1:0] ang_q, atan_s;
  logic signed [15:0]    px_q, pz_q;
  logic [3:0]            it_q;
  logic                  keep_q, rd_ok_q;
  logic [AW-1:0]         rb_addr_q;
  logic [8:0]            rb_q;

  assign dx     = y_q >>> it_q;
  assign dy     = x_q >>> it_q;
  assign atan_s = signed'({4'd0, atan_lut(it_q)});

  // skip counter, frame flag and kept-point flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      fiu_q  <= 1'b0;
      keep_q <= 1'b0;
    end else if (cmd_i.load) begin
      keep_q <= sts_o.keep_now;
      if (fs_now) begin
        skip_q <= use_now ? 8'd0 : cnt1;
        fiu_q  <= use_now;
      end
    end
  end

  // iteration counter shared by CORDIC and isqrt
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.load || cmd_i.sqrt_init) begin
      it_q <= '0;
    end else if (cmd_i.cordic_step || cmd_i.sqrt_step) begin
      it_q <= it_q + 4'd1;
    end
  end

  assign sts_o.cordic_done = it_q == 4'(CORDIC_STEPS - 1);
  assign sts_o.sqrt_done   = it_q == 4'(SQRT_STEPS - 1);
  assign sts_o.keep_q      = keep_q;

  // transaction capture and CORDIC iterations
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q      <= point_x_i;
      pz_q      <= point_z_i;
      rb_q      <= read_bin_i;
      rd_ok_q   <= {23'd0, read_bin_i} < 32'(BIN_COUNT);
      rb_addr_q <= AW'({23'd0, read_bin_i});
      x_q       <= CW'(x0) <<< 8;
      y_q       <= CW'(y0) <<< 8;
      ang_q     <= a0;
    end else if (cmd_i.cordic_step) begin
      if (y_q >= 0) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + atan_s;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - atan_s;
      end
    end
  end

  // bin scaling and squared range
  logic signed [DFW-1:0] diff;
  logic signed [PRW-1:0] prod_q;
  logic signed [31:0]    pxe, pze;
  logic [31:0]           sqx_q, sqz_q, sq_q;

  assign diff = DFW'(ang_q) - DFW'(start_q);
  assign pxe  = 32'(px_q);
  assign pze  = 32'(pz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_mul) begin
      prod_q <= PRW'(diff) * PRW'(signed'({1'b0, scale_q}));
      sqx_q  <= unsigned'(pxe * pxe);
      sqz_q  <= unsigned'(pze * pze);
    end
  end

  // truncate toward zero; just-negative values go to bin 0
  logic [15:0]   idx16;
  logic [AW-1:0] idx_addr, idx_q;
  logic          idx_ok;

  always_comb begin
    idx16    = prod_q[PRW-1] ? 16'd0 : prod_q[PRW-1:BIN_SHIFT];
    idx_addr = AW'({16'd0, idx16});
    idx_ok   = (prod_q > IDX_NEG_LIM) && ({16'd0, idx16} < 32'(BIN_COUNT));
  end

  assign sts_o.idx_ok = idx_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_calc) begin
      idx_q <= idx_addr;
      sq_q  <= sqx_q + sqz_q;
    end
  end

  // bin store clearing sweep
  logic [AW-1:0] clr_q;

  assign sts_o.clr_done = clr_q == AW'(BIN_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= sts_o.clr_done ? '0 : clr_q + 1'b1;
    end
  end

  // bin store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = cmd_i.clr_step || (cmd_i.upd && (ram_rdata < sq_q));
    ram_waddr = cmd_i.clr_step ? clr_q : idx_q;
    ram_wdata = cmd_i.clr_step ? 32'd0 : sq_q;
    ram_raddr = cmd_i.rd_issue ? rb_addr_q : idx_addr;
  end

  dpls_ram #(
    .WIDTH (32),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // digit-by-digit square root, one result bit per cycle
  logic [31:0] rem_q, res_q, sbit, ssum;

  assign sbit = 32'h4000_0000 >> {it_q, 1'b0};
  assign ssum = res_q + sbit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q <= rd_ok_q ? ram_rdata : 32'd0;
      res_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= ssum) begin
        rem_q <= rem_q - ssum;
        res_q <= (res_q >> 1) + sbit;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  // output register
  logic        out_v_q;
  logic [8:0]  obin_q;
  logic [15:0] orange_q;

  assign sts_o.out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      obin_q   <= rb_q;
      orange_q <= res_q[15:0];
    end
  end

  assign out_valid_o  = out_v_q;
  assign bin_number_o = obin_q;
  assign range_mm_o   = orange_q;

endmodule

// ===== rtl/core/dpls_ctrl.sv =====
// Controller state machine sequencing clear, point update and bin read.
`timescale 1ns / 1ps
module dpls_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpls_pkg::sts_t sts_i,
  output dpls_pkg::cmd_t cmd_o
);
  import dpls_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = sts_i.keep_q ? ST_CORDIC : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_read)       state_d = ST_RD;
          else if (sts_i.clr_now)  state_d = ST_CLEAR;
          else if (sts_i.keep_now) state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (sts_i.cordic_done) state_d = ST_BIN;
      end
      ST_BIN:    state_d = ST_IDX;
      ST_IDX:    state_d = sts_i.idx_ok ? ST_UPD : ST_IDLE;
      ST_UPD:    state_d = ST_IDLE;
      ST_RD:     state_d = ST_SQINIT;
      ST_SQINIT: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sts_i.sqrt_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CORDIC: cmd_o.cordic_step = 1'b1;
      ST_BIN:    cmd_o.bin_mul     = 1'b1;
      ST_IDX:    cmd_o.idx_calc    = 1'b1;
      ST_UPD:    cmd_o.upd         = 1'b1;
      ST_RD:     cmd_o.rd_issue    = 1'b1;
      ST_SQINIT: cmd_o.sqrt_init   = 1'b1;
      ST_SQRT:   cmd_o.sqrt_step   = 1'b1;
      ST_DONE:   cmd_o.out_load    = sts_i.out_free;
      default:   ;
    endcase
  end

endmodule

// ===== rtl/core/dpls_checker.sv =====
// Port-level assertions for the laser scan block, bound to the top level.
`timescale 1ns / 1ps
module dpls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_type_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [8:0]  bin_i,
  input logic [15:0] range_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bin_i) && $stable(range_i))
    else $error("result changed while stalled");

  // point transactions never raise a result
  a_point_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_type_i |=> !$rose(out_valid_i))
    else $error("result after point transaction");

  // a read keeps the block busy for its square root
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_type_i |=> !in_ready_i)
    else $error("ready right after read transaction");

  // range cannot exceed the square root of a 32-bit sum of squares
  a_range_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> range_i <= 16'd46341)
    else $error("range out of bounds");

endmodule

bind depth_points_to_laser_scan dpls_checker u_dpls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_type_i   (req_i.req_type),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .bin_i       (res_o.bin_number),
  .range_i     (res_o.range_mm)
);
